/* src/lsf_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_pkg: shared definitions for the learning switch forwarder
// Field widths, register indexes, default parameters and the types that move
// between the address table cells and the top level.
// ----------------------------------------------------------------------------
package lsf_pkg;

  localparam int unsigned MAC_W       = 48;
  localparam int unsigned PORT_W      = 3;
  localparam int unsigned MASK_W      = 8;
  localparam int unsigned CFG_INDEX_W = 8;

  localparam int unsigned DEFAULT_TABLE_DEPTH = 64;
  localparam int unsigned DEFAULT_PORT_COUNT  = 8;
  localparam int unsigned DEFAULT_COUNT_W     = 7;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_W-1:0] REG_BLOCKED_PORTS = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_ACTIVE_PORTS  = 8'd1;

  localparam logic [MASK_W-1:0] BLOCKED_RESET = 8'h00;
  localparam logic [MASK_W-1:0] ACTIVE_RESET  = 8'hFF;

  // One frame header walking down the table, with what it has found so far.
  typedef struct packed {
    logic              valid;
    logic [MAC_W-1:0]  src;
    logic [MAC_W-1:0]  dst;
    logic [PORT_W-1:0] arr;
    logic              src_hit;
    logic              dst_hit;
    logic [PORT_W-1:0] dst_port;
  } lsf_token_t;

  // Write of a new entry into the first free cell.
  typedef struct packed {
    logic              en;
    logic [MAC_W-1:0]  mac;
    logic [PORT_W-1:0] port;
  } lsf_append_t;

endpackage
`default_nettype wire

/* src/lsf_cell.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lsf_cell: one entry of the address table
// Holds one learned address and its port, compares it against the header
// passing through, relearns the port on a source match and hands the header
// on to the next cell through its header register.
// ----------------------------------------------------------------------------
module lsf_cell #(
  parameter int unsigned CELL_INDEX = 0,
  parameter int unsigned COUNT_W    = lsf_pkg::DEFAULT_COUNT_W
) (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire  [COUNT_W-1:0]  count_i,
  input  lsf_pkg::lsf_append_t append_i,
  input  lsf_pkg::lsf_token_t  tok_i,
  output lsf_pkg::lsf_token_t  tok_o
);

  logic [lsf_pkg::MAC_W-1:0]  addr_r;
  logic [lsf_pkg::PORT_W-1:0] port_r;
  lsf_pkg::lsf_token_t        tok_r;
  lsf_pkg::lsf_token_t        tok_nxt;

  logic live;
  logic src_match;
  logic dst_match;
  logic append_here;

  // An entry counts only once the fill count has passed it.
  assign live        = count_i > COUNT_W'(CELL_INDEX);
  assign src_match   = tok_i.valid && live && (addr_r == tok_i.src);
  assign dst_match   = tok_i.valid && live && (addr_r == tok_i.dst);
  assign append_here = append_i.en && (count_i == COUNT_W'(CELL_INDEX));

  always_comb begin
    tok_nxt         = tok_i;
    tok_nxt.src_hit = tok_i.src_hit | src_match;
    tok_nxt.dst_hit = tok_i.dst_hit | dst_match;
    if (dst_match) begin
      // When source and destination are the same entry, the fresh port wins.
      tok_nxt.dst_port = src_match ? tok_i.arr : port_r;
    end
  end

  always_ff @(posedge clk) begin
    if (append_here) begin
      addr_r <= append_i.mac;
      port_r <= append_i.port;
    end else if (src_match) begin
      port_r <= tok_i.arr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r.valid <= 1'b0;
    end else begin
      tok_r.valid <= tok_nxt.valid;
    end
    tok_r.src      <= tok_nxt.src;
    tok_r.dst      <= tok_nxt.dst;
    tok_r.arr      <= tok_nxt.arr;
    tok_r.src_hit  <= tok_nxt.src_hit;
    tok_r.dst_hit  <= tok_nxt.dst_hit;
    tok_r.dst_port <= tok_nxt.dst_port;
  end

  assign tok_o = tok_r;

endmodule
`default_nettype wire

/* src/learning_switch_forwarder.sv */
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// learning_switch_forwarder: learning bridge with a MAC address table
// Learns source addresses per port and forwards, floods or rejects each frame header.
// ----------------------------------------------------------------------------
// One frame header is taken per input transaction and one result transaction
// comes out for it. The address table is a row of TABLE_DEPTH cells, and the
// header walks through it one cell per cycle. The next header is taken only
// once the walk is done and its result has left the pending register; a
// frame on a blocked port skips the table and goes to the pending register.
// Only one header is in the table at a time. A result that is not yet taken
// sits in the output register while the next header may already be accepted,
// provided the table walk has room to finish.
// Address and port entries hold no defined contents after reset; the fill
// count alone marks which cells are live, so no clearing pass is needed.
// Configuration writes are always accepted and must only be issued while no
// frame is in flight.
// ----------------------------------------------------------------------------
module learning_switch_forwarder #(
  parameter int unsigned TABLE_DEPTH = lsf_pkg::DEFAULT_TABLE_DEPTH,
  parameter int unsigned PORT_COUNT  = lsf_pkg::DEFAULT_PORT_COUNT
) (
  input  wire                              clk,
  input  wire                              rst_n,
  // Frame header input
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire  [lsf_pkg::MAC_W-1:0]        in_source_mac,
  input  wire  [lsf_pkg::MAC_W-1:0]        in_dest_mac,
  input  wire  [lsf_pkg::PORT_W-1:0]       in_arrival_port,
  // Forwarding result output
  output logic                             out_valid,
  input  wire                              out_ready,
  output logic [lsf_pkg::MASK_W-1:0]       out_forward_mask,
  output logic                             out_rejected,
  output logic                             out_dest_known,
  output logic                             out_learn_dropped,
  // Configuration write port
  input  wire                              cfg_valid,
  output logic                             cfg_ready,
  input  wire  [lsf_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  wire  [lsf_pkg::MASK_W-1:0]       cfg_data
);

  localparam int unsigned CountW    = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned PortsUsed =
    (PORT_COUNT > lsf_pkg::MASK_W) ? lsf_pkg::MASK_W : PORT_COUNT;
  // Register bits for ports beyond the port count are ignored.
  localparam logic [lsf_pkg::MASK_W-1:0] PortValid =
    lsf_pkg::MASK_W'((64'd1 << PortsUsed) - 64'd1);

  // Configuration registers.
  logic [lsf_pkg::MASK_W-1:0] blocked_r;
  logic [lsf_pkg::MASK_W-1:0] active_r;
  logic [lsf_pkg::MASK_W-1:0] blocked_eff;
  logic [lsf_pkg::MASK_W-1:0] active_eff;

  assign cfg_ready   = 1'b1;
  assign blocked_eff = blocked_r & PortValid;
  assign active_eff  = active_r & PortValid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blocked_r <= lsf_pkg::BLOCKED_RESET;
      active_r  <= lsf_pkg::ACTIVE_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsf_pkg::REG_BLOCKED_PORTS: blocked_r <= cfg_data;
        lsf_pkg::REG_ACTIVE_PORTS:  active_r  <= cfg_data;
        default: ;  // Writes to unknown indexes are dropped.
      endcase
    end
  end

  // Control: run_r is high while a header walks the table, pend_v_r while a
  // finished result waits for the output register.
  logic                       run_r;
  logic                       run_nxt;
  logic                       pend_v_r;
  logic                       pend_v_nxt;
  logic [lsf_pkg::MASK_W-1:0] pend_mask_r;
  logic                       pend_rej_r;
  logic                       pend_known_r;
  logic                       pend_drop_r;
  logic [lsf_pkg::MASK_W-1:0] pend_mask_nxt;
  logic                       pend_rej_nxt;
  logic                       pend_known_nxt;
  logic                       pend_drop_nxt;
  logic                       pend_move;

  logic                       out_valid_r;
  logic                       out_valid_nxt;
  logic [lsf_pkg::MASK_W-1:0] out_mask_r;
  logic                       out_rej_r;
  logic                       out_known_r;
  logic                       out_drop_r;

  logic [CountW-1:0]          count_r;
  logic [CountW-1:0]          count_nxt;

  logic                       in_accept;
  logic                       arr_blocked;

  assign in_ready    = !run_r && !pend_v_r;
  assign in_accept   = in_valid && in_ready;
  // A frame on a port that the spanning tree blocks never enters the table.
  assign arr_blocked = blocked_eff[in_arrival_port];

  // The cell chain. Entry 0 of tok is the header entering the first cell and
  // the last entry is what leaves the final cell.
  lsf_pkg::lsf_token_t  tok [TABLE_DEPTH+1];
  lsf_pkg::lsf_append_t append;
  logic [TABLE_DEPTH:0] tok_valid_vec;

  always_comb begin
    tok[0].valid    = in_accept && !arr_blocked;
    tok[0].src      = in_source_mac;
    tok[0].dst      = in_dest_mac;
    tok[0].arr      = in_arrival_port;
    tok[0].src_hit  = 1'b0;
    tok[0].dst_hit  = 1'b0;
    tok[0].dst_port = in_arrival_port;
  end

  for (genvar g = 0; g < TABLE_DEPTH; g++) begin : g_cell
    lsf_cell #(
      .CELL_INDEX (g),
      .COUNT_W    (CountW)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .count_i  (count_r),
      .append_i (append),
      .tok_i    (tok[g]),
      .tok_o    (tok[g+1])
    );
  end

  for (genvar g = 0; g <= TABLE_DEPTH; g++) begin : g_valid
    assign tok_valid_vec[g] = tok[g].valid;
  end

  // Tail of the chain: the source learning is finished here. A source that
  // no cell matched is appended to the first free cell unless the table is
  // full. A destination equal to such a freshly appended source is a hit on
  // the arrival port.
  lsf_pkg::lsf_token_t        tail;
  logic                       table_full;
  logic                       tail_hit;
  logic [lsf_pkg::PORT_W-1:0] tail_port;
  logic [lsf_pkg::MASK_W-1:0] tail_arr_bit;
  logic [lsf_pkg::MASK_W-1:0] tail_mask;

  assign tail       = tok[TABLE_DEPTH];
  assign table_full = count_r == CountW'(TABLE_DEPTH);

  always_comb begin
    append.en    = tail.valid && !tail.src_hit && !table_full;
    append.mac   = tail.src;
    append.port  = tail.arr;
    tail_hit     = tail.dst_hit ||
                   (!tail.src_hit && !table_full && (tail.dst == tail.src));
    tail_port    = tail.dst_hit ? tail.dst_port : tail.arr;
    tail_arr_bit = lsf_pkg::MASK_W'(1) << tail.arr;
    if (tail_hit) begin
      // Unicast: no blocking check, but the link must be attached.
      tail_mask = (lsf_pkg::MASK_W'(1) << tail_port) & active_eff;
    end else begin
      tail_mask = active_eff & ~blocked_eff & ~tail_arr_bit;
    end
  end

  always_comb begin
    count_nxt = count_r;
    if (append.en) begin
      count_nxt = count_r + CountW'(1);
    end
  end

  // Pending result and output register.
  assign pend_move = pend_v_r && (!out_valid_r || out_ready);

  always_comb begin
    pend_v_nxt     = pend_v_r && !pend_move;
    pend_mask_nxt  = pend_mask_r;
    pend_rej_nxt   = pend_rej_r;
    pend_known_nxt = pend_known_r;
    pend_drop_nxt  = pend_drop_r;
    if (in_accept && arr_blocked) begin
      pend_v_nxt     = 1'b1;
      pend_mask_nxt  = '0;
      pend_rej_nxt   = 1'b1;
      pend_known_nxt = 1'b0;
      pend_drop_nxt  = 1'b0;
    end else if (tail.valid) begin
      pend_v_nxt     = 1'b1;
      pend_mask_nxt  = tail_mask;
      pend_rej_nxt   = 1'b0;
      pend_known_nxt = tail_hit;
      pend_drop_nxt  = !tail.src_hit && table_full;
    end
  end

  always_comb begin
    run_nxt = run_r;
    if (tail.valid) begin
      run_nxt = 1'b0;
    end
    if (tok[0].valid) begin
      run_nxt = 1'b1;
    end
  end

  assign out_valid_nxt = pend_move || (out_valid_r && !out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= 1'b0;
      pend_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
      count_r     <= '0;
    end else begin
      run_r       <= run_nxt;
      pend_v_r    <= pend_v_nxt;
      out_valid_r <= out_valid_nxt;
      count_r     <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pend_mask_r  <= pend_mask_nxt;
    pend_rej_r   <= pend_rej_nxt;
    pend_known_r <= pend_known_nxt;
    pend_drop_r  <= pend_drop_nxt;
    if (pend_move) begin
      out_mask_r  <= pend_mask_r;
      out_rej_r   <= pend_rej_r;
      out_known_r <= pend_known_r;
      out_drop_r  <= pend_drop_r;
    end
  end

  assign out_valid         = out_valid_r;
  assign out_forward_mask  = out_mask_r;
  assign out_rejected      = out_rej_r;
  assign out_dest_known    = out_known_r;
  assign out_learn_dropped = out_drop_r;

  // Only one header may be in the table at any time.
  a_single_header : assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(tok_valid_vec))
    else $error("more than one header in the address table");

  // A header leaving the table must belong to a walk that is in progress.
  a_tail_in_run : assert property (@(posedge clk) disable iff (!rst_n)
    tail.valid |-> run_r && !pend_v_r)
    else $error("header left the table outside a walk");

  // The fill count never passes the table depth.
  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CountW'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  // A rejected frame forwards nothing and reports no learning or hit.
  a_reject_clean : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_rej_r |-> out_mask_r == '0 && !out_known_r && !out_drop_r)
    else $error("rejected frame with non-zero result fields");

endmodule
`default_nettype wire
